>>> rtl/sst_pkg.sv
package sst_pkg;

   localparam int MaxEntries = 1024;
   localparam int MaxLen = 8;
   localparam int ItemBits = 16;
   localparam int IdxBits = $clog2(MaxEntries);
   localparam int CntBits = $clog2(MaxEntries + 1);
   localparam int PosBits = $clog2(MaxLen);
   localparam int LenBits = $clog2(MaxLen + 1);
   localparam int TplBits = 7;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef struct packed {
      logic [1:0]   command;
      logic [15:0]  item_value;
      logic         is_last;
      logic [6:0]   template_bits;
   } req_type;

   typedef struct packed {
      logic         found;
      logic [9:0]   match_index;
      logic         overflow;
   } rsp_type;

endpackage

>>> rtl/sorted_sequence_table_search.sv
// Sequence table with binary search. Load and clear requests are handled
// in the idle state. A query request that is not the last element stores
// its item; on its last element the search walks the table, one probe per
// round, up to ceil(log2(entries+1)) probes, 11 for a full table. Each
// probe takes a range check, a header read and a length compare, then a
// read state and a compare state for each item compared, from the last
// position down, stopping at the first difference; length <= 8. A closing
// range check (when no entry matches) and the result post end the search,
// and no new request is taken until the result has been accepted.
// Item and header memories are synchronous, with registered read data.
module sorted_sequence_table_search (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sst_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sst_pkg::rsp_type rsp_data
);
   import sst_pkg::*;

   localparam int ItemAddrBits = IdxBits + PosBits;

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_HEAD, S_LAST, S_FETCH, S_WALK, S_DONE
   } state_type;

   state_type state_ff;

   logic [ItemBits-1:0] item_mem [MaxEntries*MaxLen];
   logic [LenBits+TplBits-1:0] head_mem [MaxEntries];

   logic [ItemBits-1:0] query_ff [MaxLen];
   logic [CntBits-1:0]  count_ff;
   logic [LenBits-1:0]  ptr_ff;
   logic [LenBits-1:0]  qlen_ff;
   logic [TplBits-1:0]  qtpl_ff;
   logic                ovf_ff;

   // search range, signed by one extra bit so hi can go to -1
   logic signed [CntBits:0] lo_ff, hi_ff;
   logic [IdxBits-1:0]  mid_ff;
   logic [PosBits-1:0]  pos_ff;     // item position being compared
   logic [PosBits-1:0]  bpos_ff;    // template bit step
   logic [TplBits-1:0]  etpl_ff;
   logic [LenBits-1:0]  elen_ff;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [ItemAddrBits-1:0] rd_addr;
   logic [ItemBits-1:0]     rd_item_ff;
   logic [LenBits+TplBits-1:0] rd_head_ff;

   logic accept;
   logic [ItemBits-1:0] item_in;
   logic signed [CntBits+1:0] mid_sum;
   logic signed [CntBits:0] mid_dec, mid_inc;
   logic [ItemBits-1:0] qitem;
   logic tb_e, tb_q;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign item_in = req_data.item_value[ItemBits-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign mid_sum = {lo_ff[CntBits], lo_ff} + {hi_ff[CntBits], hi_ff};
   assign mid_dec = $signed({1'b0, CntBits'(mid_ff)} - (CntBits+1)'(1));
   assign mid_inc = $signed({1'b0, CntBits'(mid_ff)} + (CntBits+1)'(1));
   assign qitem = query_ff[pos_ff];
   assign tb_e = etpl_ff[bpos_ff < PosBits'(TplBits) ? bpos_ff : '0] &&
                 (bpos_ff < PosBits'(TplBits));
   assign tb_q = qtpl_ff[bpos_ff < PosBits'(TplBits) ? bpos_ff : '0] &&
                 (bpos_ff < PosBits'(TplBits));

   always_comb begin
      rd_addr = {mid_ff, pos_ff};
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept && req_data.command == CMD_LOAD && count_ff < CntBits'(MaxEntries)) begin
         if (ptr_ff < LenBits'(MaxLen))
            item_mem[{count_ff[IdxBits-1:0], ptr_ff[PosBits-1:0]}] <= item_in;
         if (req_data.is_last)
            head_mem[count_ff[IdxBits-1:0]] <=
               {(ptr_ff < LenBits'(MaxLen)) ? ptr_ff + LenBits'(1) : ptr_ff,
                req_data.template_bits};
      end
      rd_item_ff <= item_mem[rd_addr];
      rd_head_ff <= head_mem[mid_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ptr_ff <= '0;
         qlen_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MaxLen; k++) query_ff[k] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (req_data.command)
                     CMD_CLEAR: begin
                        count_ff <= '0;
                        ptr_ff <= '0;
                        qlen_ff <= '0;
                        ovf_ff <= 1'b0;
                     end
                     CMD_LOAD: begin
                        if (count_ff >= CntBits'(MaxEntries) || ptr_ff >= LenBits'(MaxLen))
                           ovf_ff <= 1'b1;
                        if (req_data.is_last) begin
                           if (count_ff < CntBits'(MaxEntries))
                              count_ff <= count_ff + CntBits'(1);
                           ptr_ff <= '0;
                        end else if (ptr_ff < LenBits'(MaxLen)) begin
                           ptr_ff <= ptr_ff + LenBits'(1);
                        end
                     end
                     CMD_QUERY: begin
                        if (ptr_ff < LenBits'(MaxLen))
                           query_ff[ptr_ff[PosBits-1:0]] <= item_in;
                        else
                           ovf_ff <= 1'b1;
                        if (req_data.is_last) begin
                           qlen_ff <= (ptr_ff < LenBits'(MaxLen)) ?
                                      ptr_ff + LenBits'(1) : ptr_ff;
                           ptr_ff <= '0;
                           qtpl_ff <= req_data.template_bits;
                           lo_ff <= '0;
                           hi_ff <= $signed({1'b0, count_ff} - (CntBits+1)'(1));
                           rsp_ff.found <= 1'b0;
                           rsp_ff.match_index <= '0;
                           state_ff <= S_PROBE;
                        end else if (ptr_ff < LenBits'(MaxLen)) begin
                           ptr_ff <= ptr_ff + LenBits'(1);
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_PROBE: begin
               if (lo_ff > hi_ff) begin
                  state_ff <= S_DONE;
               end else begin
                  mid_ff <= IdxBits'(mid_sum >>> 1);
                  state_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               // head read of mid issued this cycle, data next
               pos_ff <= '0;
               state_ff <= S_LAST;
               elen_ff <= '0;
            end
            S_LAST: begin
               if (elen_ff == '0) begin
                  // header arrived; compare lengths, fetch last item if they are equal
                  elen_ff <= rd_head_ff[LenBits+TplBits-1:TplBits];
                  etpl_ff <= rd_head_ff[TplBits-1:0];
                  if (rd_head_ff[LenBits+TplBits-1:TplBits] > qlen_ff) begin
                     hi_ff <= mid_dec;
                     state_ff <= S_PROBE;
                  end else if (rd_head_ff[LenBits+TplBits-1:TplBits] < qlen_ff) begin
                     lo_ff <= mid_inc;
                     state_ff <= S_PROBE;
                  end else begin
                     pos_ff <= PosBits'(rd_head_ff[LenBits+TplBits-1:TplBits] - 1);
                     bpos_ff <= '0;
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               // item at pos_ff is read at this edge
               state_ff <= S_WALK;
            end
            S_WALK: begin
               state_ff <= S_DONE;
               if (rd_item_ff < qitem) begin
                  hi_ff <= mid_dec;
                  state_ff <= S_PROBE;
               end else if (rd_item_ff > qitem) begin
                  lo_ff <= mid_inc;
                  state_ff <= S_PROBE;
               end else if (pos_ff == '0) begin
                  rsp_ff.found <= 1'b1;
                  rsp_ff.match_index <= 10'(mid_ff);
               end else if (!tb_e && tb_q) begin
                  hi_ff <= mid_dec;
                  state_ff <= S_PROBE;
               end else if (tb_e && !tb_q) begin
                  lo_ff <= mid_inc;
                  state_ff <= S_PROBE;
               end else begin
                  pos_ff <= pos_ff - PosBits'(1);
                  bpos_ff <= bpos_ff + PosBits'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_DONE: begin
               rsp_ff.overflow <= ovf_ff;
               ovf_ff <= 1'b0;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data));
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready);
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready));
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(MaxEntries));
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LenBits'(MaxLen));

endmodule
